### hw/rtl/rtd_voltage_to_temperature_unit_assert.svh
// ----------------------------------------------------------------------------
// RTD converter assertion macros
// Shared property macros for the RTD voltage to temperature unit.
// ----------------------------------------------------------------------------
`ifndef RTD_VOLTAGE_TO_TEMPERATURE_UNIT_ASSERT_SVH
`define RTD_VOLTAGE_TO_TEMPERATURE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RTDV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RTDV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rtdv_pkg.sv
// ----------------------------------------------------------------------------
// RTD converter package
// Field widths, calibration ROM, output limits and sequencer states.
// ----------------------------------------------------------------------------
package rtdv_pkg;

  localparam int SAMPLE_W = 22;
  localparam int RES_W    = 19;
  localparam int TEMP_W   = 22;

  localparam int DIV_NUM_W  = 46;
  localparam int DIV_DEN_W  = 27;
  localparam int SQRT_OP_W  = 60;
  localparam int SQRT_ROOT_W = SQRT_OP_W / 2;

  localparam int CAL_POINTS = 11;
  localparam int CAL_IDX_W  = $clog2(CAL_POINTS);

  // measured and actual calibration points, milliohms
  localparam logic [RES_W-1:0] CAL_MEASURED [CAL_POINTS] = '{
    19'd80500, 19'd82500, 19'd99900, 19'd106900, 19'd112800, 19'd115365,
    19'd123900, 19'd130600, 19'd139800, 19'd150850, 19'd153810
  };
  localparam logic [RES_W-1:0] CAL_ACTUAL [CAL_POINTS] = '{
    19'd81000, 19'd83800, 19'd100000, 19'd107600, 19'd113300, 19'd115300,
    19'd124000, 19'd130800, 19'd137000, 19'd150000, 19'd154000
  };

  localparam logic [RES_W-1:0]         R_MAX_MOHM = 19'd400000;
  localparam logic signed [TEMP_W-1:0] T_MIN_MDEG = -22'sd300000;
  localparam logic signed [TEMP_W-1:0] T_MAX_MDEG = 22'sd1100000;
  localparam logic signed [TEMP_W-1:0] T_ERR_MDEG = -22'sd999000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RAW_MUL,
    ST_RAW_GO,
    ST_RAW_WAIT,
    ST_SEG,
    ST_CAL_MUL,
    ST_CAL_PREP,
    ST_CAL_GO,
    ST_CAL_WAIT,
    ST_CAL_FIX,
    ST_DISC,
    ST_SQ_LO,
    ST_SQ_HI,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_TMP_GO,
    ST_TMP_WAIT,
    ST_DONE
  } state_t;

endpackage

### hw/rtl/rtdv_divider.sv
// ----------------------------------------------------------------------------
// RTD converter serial divider
// Restoring divider, one quotient bit per cycle, dividend shifted MSB first.
// ----------------------------------------------------------------------------
module rtdv_divider #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 27
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, sh[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign quo   = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(NUM_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // shift one dividend bit in, one quotient bit out
  always_ff @(posedge clk) begin
    if (start) begin
      sh    <= num;
      rem   <= '0;
      den_q <= den;
    end else if (running) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      sh  <= {sh[NUM_W-2:0], ge};
    end
  end

endmodule

### hw/rtl/rtdv_isqrt.sv
// ----------------------------------------------------------------------------
// RTD converter serial square root
// Floor square root, two operand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module rtdv_isqrt #(
  parameter int OP_W = 60
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [OP_W-1:0]     op,
  output logic                done,
  output logic [OP_W/2-1:0]   root
);

  localparam int ROOT_W = OP_W / 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  logic [OP_W-1:0]   op_sh;
  logic [ROOT_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              running;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  assign rem_sh = {rem, op_sh[OP_W-1:OP_W-2]};
  assign trial  = {root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(ROOT_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // the remainder stays below 2*root+1, so its low bits carry it
  always_ff @(posedge clk) begin
    if (start) begin
      op_sh <= op;
      rem   <= '0;
      root  <= '0;
    end else if (running) begin
      rem   <= ge ? ROOT_W'(rem_sh - trial) : ROOT_W'(rem_sh);
      root  <= {root[ROOT_W-2:0], ge};
      op_sh <= {op_sh[OP_W-3:0], 2'b00};
    end
  end

endmodule

### hw/rtl/rtd_voltage_to_temperature_unit.sv
// ----------------------------------------------------------------------------
// RTD voltage to temperature unit
// PT100 bridge voltage to calibrated resistance and temperature.
// ----------------------------------------------------------------------------
// Usage:
//   Drive sample_uv (signed microvolts) and raise start while busy is low;
//   the word is taken on that clock edge. busy stays high until the result
//   has been shown. One word in gives one result word out.
//   The result (resistance_mohm, temperature_mdeg, out_of_range) is valid
//   for exactly one cycle while done is high; the receiver cannot stall,
//   so it must capture the word in that cycle. The ports hold their value
//   afterwards, but only the strobed cycle counts.
//   The time from the accepting edge to the result depends on the shared
//   serial divider (used up to three times), the serial square root and
//   the calibration segment scan. One word is in flight at a time, so a
//   new word is taken only once busy has dropped after the result strobe.
//   A synchronous, active-high rst returns the sequencer to idle, drops
//   any word in flight and clears the strobe; no result follows.
// ----------------------------------------------------------------------------
module rtd_voltage_to_temperature_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rtdv_pkg::SAMPLE_W-1:0] sample_uv,
  output logic                                 done,
  output logic        [rtdv_pkg::RES_W-1:0]    resistance_mohm,
  output logic signed [rtdv_pkg::TEMP_W-1:0]   temperature_mdeg,
  output logic                                 out_of_range
);

  import rtdv_pkg::*;

  `include "rtd_voltage_to_temperature_unit_assert.svh"

  state_t state, state_next;

  // datapath registers
  logic        [24:0]            x_reg;      // 14584000 - 5*u, always positive
  logic        [DIV_NUM_W-1:0]   num_reg;
  logic        [DIV_DEN_W-1:0]   den_reg;
  logic                          neg_reg;
  logic        [RES_W-1:0]       r_reg;
  logic        [CAL_IDX_W-1:0]   idx;
  logic        [CAL_IDX_W-1:0]   seg;
  logic signed [41:0]            prod_reg;
  logic        [20:0]            dmag_reg;
  logic                          dm_zero;
  logic        [DIV_NUM_W-1:0]   q_reg;
  logic signed [35:0]            d_reg;
  logic        [SQRT_OP_W-1:0]   v_reg;
  logic        [RES_W-1:0]       res_reg;
  logic signed [TEMP_W-1:0]      temp_reg;
  logic                          err_reg;

  // unit handshakes
  logic                    div_start, div_done;
  logic [DIV_NUM_W-1:0]    div_quo;
  logic                    sq_start, sq_done;
  logic [SQRT_ROOT_W-1:0]  sq_root;

  // segment search
  logic seg_low, seg_high, seg_hit, seg_last;

  // combinational datapath terms
  logic signed [25:0] x_next;
  logic        [44:0] raw_prod;
  logic signed [20:0] cal_diff, cal_dm, cal_da;
  logic signed [20:0] diff_eff;
  logic        [20:0] dmag_eff;
  logic        [41:0] prod_mag;
  logic signed [47:0] cal_sum;
  logic signed [20:0] k_term;
  logic signed [35:0] dk;
  logic        [41:0] v_lo;
  logic        [40:0] v_hi;
  logic signed [30:0] tn;
  logic        [30:0] tn_mag;
  logic signed [47:0] t_sum;

  rtdv_divider #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_reg),
    .den   (den_reg),
    .done  (div_done),
    .quo   (div_quo)
  );

  rtdv_isqrt #(
    .OP_W (SQRT_OP_W)
  ) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .op    (v_reg),
    .done  (sq_done),
    .root  (sq_root)
  );

  // scan one calibration segment per cycle; the end segments catch
  // anything outside the table
  assign seg_low  = r_reg <= CAL_MEASURED[0];
  assign seg_high = r_reg >= CAL_MEASURED[CAL_POINTS-1];
  assign seg_hit  = (r_reg >= CAL_MEASURED[idx]) &&
                    (r_reg <= CAL_MEASURED[idx + 1'b1]);
  assign seg_last = idx == CAL_IDX_W'(CAL_POINTS - 2);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (start) state_next = ST_RAW_MUL;
      ST_RAW_MUL:  state_next = ST_RAW_GO;
      ST_RAW_GO:   state_next = ST_RAW_WAIT;
      ST_RAW_WAIT: if (div_done) state_next = ST_SEG;
      ST_SEG:      if (seg_low || seg_high || seg_hit || seg_last) state_next = ST_CAL_MUL;
      ST_CAL_MUL:  state_next = ST_CAL_PREP;
      ST_CAL_PREP: state_next = dm_zero ? ST_CAL_FIX : ST_CAL_GO;
      ST_CAL_GO:   state_next = ST_CAL_WAIT;
      ST_CAL_WAIT: if (div_done) state_next = ST_CAL_FIX;
      ST_CAL_FIX:  state_next = ST_DISC;
      ST_DISC:     state_next = ST_SQ_LO;
      ST_SQ_LO:    state_next = d_reg[35] ? ST_DONE : ST_SQ_HI;
      ST_SQ_HI:    state_next = ST_SQ_GO;
      ST_SQ_GO:    state_next = ST_SQ_WAIT;
      ST_SQ_WAIT:  if (sq_done) state_next = ST_TMP_GO;
      ST_TMP_GO:   state_next = ST_TMP_WAIT;
      ST_TMP_WAIT: if (div_done) state_next = ST_DONE;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy      = state != ST_IDLE;
    done      = state == ST_DONE;
    div_start = (state == ST_RAW_GO) || (state == ST_CAL_GO) || (state == ST_TMP_GO);
    sq_start  = state == ST_SQ_GO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // arithmetic terms
  always_comb begin
    x_next   = 26'sd14584000 - (26'(sample_uv) * 26'sd5);
    raw_prod = x_reg * 20'd625000;

    cal_diff = $signed({2'b00, r_reg}) - $signed({2'b00, CAL_MEASURED[seg]});
    cal_dm   = $signed({2'b00, CAL_MEASURED[seg + 1'b1]}) -
               $signed({2'b00, CAL_MEASURED[seg]});
    cal_da   = $signed({2'b00, CAL_ACTUAL[seg + 1'b1]}) -
               $signed({2'b00, CAL_ACTUAL[seg]});
    // a falling segment divides by the magnitude with the offset negated
    diff_eff = cal_dm[20] ? -cal_diff : cal_diff;
    dmag_eff = cal_dm[20] ? 21'(-cal_dm) : 21'(cal_dm);

    prod_mag = prod_reg[41] ? 42'(-prod_reg) : 42'(prod_reg);
    cal_sum  = $signed({29'b0, CAL_ACTUAL[seg]}) +
               (neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg}));

    k_term = 21'sd100000 - $signed({2'b00, res_reg});
    dk     = k_term * 16'sd23100;

    v_lo = d_reg[17:0] * 24'd10000000;
    v_hi = d_reg[34:18] * 24'd10000000;

    tn     = (31'sd390830000 - $signed({1'b0, sq_root})) * 31'sd2;
    tn_mag = tn[30] ? 31'(-tn) : 31'(tn);
    t_sum  = neg_reg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
  end

  // datapath: advance one step per sequencer state
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) x_reg <= x_next[24:0];
      end
      ST_RAW_MUL: begin
        // round to nearest: add half the divisor, positive numerator
        num_reg <= DIV_NUM_W'(raw_prod) + DIV_NUM_W'(25052494);
        den_reg <= DIV_DEN_W'(50104989);
      end
      ST_RAW_WAIT: begin
        if (div_done) begin
          r_reg <= div_quo[RES_W-1:0];
          idx   <= '0;
        end
      end
      ST_SEG: begin
        idx <= idx + 1'b1;
        if (seg_low) begin
          seg <= '0;
        end else if (seg_high || !seg_hit) begin
          seg <= CAL_IDX_W'(CAL_POINTS - 2);
        end else begin
          seg <= idx;
        end
      end
      ST_CAL_MUL: begin
        prod_reg <= diff_eff * cal_da;
        dmag_reg <= dmag_eff;
        dm_zero  <= cal_dm == 21'sd0;
      end
      ST_CAL_PREP: begin
        num_reg <= DIV_NUM_W'(prod_mag) + DIV_NUM_W'(dmag_reg >> 1);
        den_reg <= DIV_DEN_W'(dmag_reg);
        neg_reg <= prod_reg[41];
        q_reg   <= '0;
      end
      ST_CAL_WAIT: begin
        if (div_done) q_reg <= div_quo;
      end
      ST_CAL_FIX: begin
        if (cal_sum < 48'sd0) begin
          res_reg <= '0;
        end else if (cal_sum > $signed({29'b0, R_MAX_MOHM})) begin
          res_reg <= R_MAX_MOHM;
        end else begin
          res_reg <= cal_sum[RES_W-1:0];
        end
      end
      ST_DISC: begin
        d_reg <= 36'sd15274808890 + dk;
      end
      ST_SQ_LO: begin
        err_reg <= d_reg[35];
        if (d_reg[35]) temp_reg <= T_ERR_MDEG;
        v_reg <= {18'b0, v_lo};
      end
      ST_SQ_HI: begin
        v_reg <= v_reg + {1'b0, v_hi, 18'b0};
      end
      ST_SQ_WAIT: begin
        if (sq_done) begin
          num_reg <= DIV_NUM_W'(tn_mag) + DIV_NUM_W'(115);
          den_reg <= DIV_DEN_W'(231);
          neg_reg <= tn[30];
        end
      end
      ST_TMP_WAIT: begin
        if (div_done) begin
          if (t_sum < 48'(T_MIN_MDEG)) begin
            temp_reg <= T_MIN_MDEG;
          end else if (t_sum > 48'(T_MAX_MDEG)) begin
            temp_reg <= T_MAX_MDEG;
          end else begin
            temp_reg <= t_sum[TEMP_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign resistance_mohm  = res_reg;
  assign temperature_mdeg = temp_reg;
  assign out_of_range     = err_reg;

  // checks on the sequencer and the result word
  `RTDV_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `RTDV_ASSERT_NEXT(a_strobe_once, done, !done, "result strobe held past one cycle")
  `RTDV_ASSERT_NOW(a_res_limit, done, resistance_mohm <= R_MAX_MOHM, "resistance over limit")
  `RTDV_ASSERT_NOW(a_err_temp, done && out_of_range, temperature_mdeg == T_ERR_MDEG, "error temperature wrong")

endmodule

### tb/sv/tb_rtd_voltage_to_temperature_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RTD voltage to temperature unit testbench
// Drives bridge voltage words through the unit and checks every result word
// (calibrated resistance, temperature, range flag) against a fixed-point
// predictor of the conversion, under random start gaps and drain pauses.
// ----------------------------------------------------------------------------
module tb_rtd_voltage_to_temperature_unit;
  import rtdv_pkg::*;

  typedef struct {
    logic [RES_W-1:0]         res;
    logic signed [TEMP_W-1:0] temp;
    logic                     oor;
  } reading_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    int                         gap;
    bit                         drain;
  } sample_item_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic signed [SAMPLE_W-1:0] sample_uv;
  logic                       done;
  logic [RES_W-1:0]           resistance_mohm;
  logic signed [TEMP_W-1:0]   temperature_mdeg;
  logic                       out_of_range;

  sample_item_t pending_samples[$];
  reading_t     expected_readings[$];
  sample_item_t cur;
  bit           have_cur;
  int           gap_left;
  bit           took_word;
  int           mismatches;
  bit           failed;

  rtd_voltage_to_temperature_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .sample_uv        (sample_uv),
    .done             (done),
    .resistance_mohm  (resistance_mohm),
    .temperature_mdeg (temperature_mdeg),
    .out_of_range     (out_of_range)
  );

  // Nearest-integer quotient, ties away from zero; den is positive.
  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // Floor square root, two bits of operand per step.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Piecewise linear correction over the ROM, end segments extrapolated.
  function automatic longint calibrate_mohm(longint r);
    int     seg;
    longint m0, m1, a0, a1, dm, a;
    seg = CAL_POINTS - 2;
    if (r <= longint'(CAL_MEASURED[0])) begin
      seg = 0;
    end else if (r < longint'(CAL_MEASURED[CAL_POINTS-1])) begin
      for (int i = 0; i < CAL_POINTS - 1; i++) begin
        if (r >= longint'(CAL_MEASURED[i]) && r <= longint'(CAL_MEASURED[i+1])) begin
          seg = i;
          break;
        end
      end
    end
    m0 = CAL_MEASURED[seg];
    m1 = CAL_MEASURED[seg+1];
    a0 = CAL_ACTUAL[seg];
    a1 = CAL_ACTUAL[seg+1];
    dm = m1 - m0;
    if (dm == 0) a = a0;
    else if (dm > 0) a = a0 + round_div((r - m0) * (a1 - a0), dm);
    else a = a0 + round_div((m0 - r) * (a1 - a0), -dm);
    if (a < 0) a = 0;
    if (a > longint'(R_MAX_MOHM)) a = R_MAX_MOHM;
    return a;
  endfunction

  // Voltage -> raw resistance -> calibrated resistance -> temperature.
  function automatic reading_t convert_sample(logic signed [SAMPLE_W-1:0] s);
    reading_t        rd;
    longint          u, r, disc, t;
    longint unsigned root;
    u = s;
    r = calibrate_mohm(round_div((64'sd14584000 - 5 * u) * 625000, 50104989));
    disc = 64'sd15274808890 + 23100 * (100000 - r);
    rd.res = r[RES_W-1:0];
    rd.oor = 1'b0;
    if (disc < 0) begin
      rd.oor = 1'b1;
      rd.temp = T_ERR_MDEG;
    end else begin
      root = floor_sqrt(longint'(disc) * 10000000);
      t = round_div((64'sd390830000 - longint'(root)) * 2, 231);
      if (t < longint'(T_MIN_MDEG)) t = T_MIN_MDEG;
      if (t > longint'(T_MAX_MDEG)) t = T_MAX_MDEG;
      rd.temp = t[TEMP_W-1:0];
    end
    return rd;
  endfunction

  function automatic void add_sample(logic signed [SAMPLE_W-1:0] s, int gap, bit drain);
    sample_item_t it;
    it.sample = s;
    it.gap = gap;
    it.drain = drain;
    pending_samples.push_back(it);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset at the start of the run, once.
  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Fill the word queue: directed corners first, then random words.
  initial begin
    int pick;
    // Field extremes, stated range ends and zero.
    add_sample(22'sh200000, 0, 0);
    add_sample(22'sh1FFFFF, 0, 0);
    add_sample(-22'sd2048000, 3, 0);
    add_sample(22'sd2048000, 0, 0);
    add_sample(22'sd0, 1, 0);
    add_sample(-22'sd1, 0, 0);
    add_sample(22'sd1, 7, 0);
    // Around the first and last ROM points: extrapolate below and above.
    add_sample(22'sd1626095, 0, 0);
    add_sample(22'sd1700000, 0, 0);
    add_sample(22'sd1550000, 2, 0);
    add_sample(22'sd450668, 0, 0);
    add_sample(22'sd300000, 0, 0);
    add_sample(22'sd500000, 0, 0);
    // Drain before the next word at least once.
    add_sample(22'sd1000000, 0, 1);
    add_sample(22'sd1200000, 0, 0);
    add_sample(22'sd800000, 5, 0);
    for (int n = 0; n < 1250; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // Around the calibration span, most of the useful behavior.
        add_sample(SAMPLE_W'($urandom_range(400000, 1700000)),
                   $urandom_range(0, 7), n % 300 == 299);
      end else if (pick < 8) begin
        add_sample(SAMPLE_W'($urandom), $urandom_range(0, 7), 0);
      end else begin
        add_sample(SAMPLE_W'($urandom_range(0, 4096000)) - 22'sd2048000,
                   (pick == 9) ? 0 : $urandom_range(0, 7), 0);
      end
    end
  end

  // Driver: advance at the falling edge; hold start until the word is taken.
  initial begin
    start = 1'b0;
    sample_uv = '0;
    have_cur = 0;
    gap_left = 0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (start && took_word) start <= 1'b0;
      if (!start) begin
        if (!have_cur && pending_samples.size() != 0) begin
          cur = pending_samples.pop_front();
          have_cur = 1;
          gap_left = cur.gap;
        end
        if (have_cur) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!(cur.drain && expected_readings.size() != 0)) begin
            sample_uv <= cur.sample;
            start <= 1'b1;
            have_cur = 0;
          end
        end
      end
    end
  end

  // Monitor: check a strobed result, then log an accepted word.
  always @(posedge clk) begin
    reading_t exp_rd;
    took_word = 0;
    if (!rst) begin
      if (done) begin
        if (expected_readings.size() == 0) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: res=%0d temp=%0d oor=%0b",
                     resistance_mohm, temperature_mdeg, out_of_range);
        end else begin
          exp_rd = expected_readings.pop_front();
          if (resistance_mohm !== exp_rd.res || temperature_mdeg !== exp_rd.temp ||
              out_of_range !== exp_rd.oor) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected res=%0d temp=%0d oor=%0b, got res=%0d temp=%0d oor=%0b",
                       exp_rd.res, exp_rd.temp, exp_rd.oor,
                       resistance_mohm, temperature_mdeg, out_of_range);
          end
        end
      end
      if (start && !busy) begin
        took_word = 1;
        expected_readings.push_back(convert_sample(sample_uv));
      end
    end
  end

  // Finish once everything is sent and every result is back.
  initial begin
    failed = 0;
    mismatches = 0;
    @(negedge rst);
    wait (pending_samples.size() == 0 && !have_cur && !start &&
          expected_readings.size() == 0);
    repeat (250) @(posedge clk);
    if (!failed && expected_readings.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #15000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
